@@ sv/emmb_pkg.sv @@
// Package: shared constants, types and the arctangent table of the matrix builder.
package emmb_pkg;

	localparam int CordicSteps = 24;
	// reduce, convert to radians, the rotation steps, quadrant unfold
	localparam int CordicLat = CordicSteps + 3;

	localparam logic signed [16:0] FullTurn = 17'sd23040;
	localparam logic [14:0] QuarterTurn = 15'd5760;
	localparam logic [37:0] DegToRadQ30 = 38'd18740330;
	localparam logic signed [33:0] CordicGain = 34'sh026DD3B6A;
	localparam logic signed [31:0] OneQ16 = 32'sd65536;

	typedef logic signed [32:0] trig_t;

	typedef enum logic {
		REG_BASE_WIDTH  = 1'b0,
		REG_BASE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] fw;
		logic signed [31:0] fh;
		logic signed [31:0] fd;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} side_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0: v = 32'h3243F6A8;
			5'd1: v = 32'h1DAC6705;
			5'd2: v = 32'h0FADBAFC;
			5'd3: v = 32'h07F56EA6;
			5'd4: v = 32'h03FEAB76;
			5'd5: v = 32'h01FFD55B;
			5'd6: v = 32'h00FFFAAA;
			5'd7: v = 32'h007FFF55;
			5'd8: v = 32'h003FFFEA;
			5'd9: v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

@@ sv/emmb_cordic.sv @@
// Pipelined sine/cosine lane: angle reduction, radian conversion, CORDIC steps, unfold.
module emmb_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic signed [15:0]  angle,
	output logic                out_vld,
	output emmb_pkg::trig_t     cos_v,
	output emmb_pkg::trig_t     sin_v
);
	import emmb_pkg::*;

	logic signed [16:0] a_ext, r_a, r_b;
	logic [14:0] r;
	logic [1:0] q;
	logic [12:0] f;
	logic vld_s1;
	logic [1:0] q_s1;
	logic [12:0] f_s1;
	logic [37:0] zp;
	logic vld_s2;
	logic [1:0] q_s2;
	logic signed [33:0] z_s2;
	logic signed [33:0] x_sk [0:CordicSteps];
	logic signed [33:0] y_sk [0:CordicSteps];
	logic signed [33:0] z_sk [0:CordicSteps];
	logic [1:0] q_sk [0:CordicSteps];
	logic vld_sk [0:CordicSteps];
	logic vld_s27;
	trig_t c_s27, s_s27;

	// fold the angle into one turn, then split off the quadrant
	always_comb begin
		a_ext = {angle[15], angle};
		r_a = (a_ext < 0) ? a_ext + FullTurn : a_ext;
		if (r_a < 0) begin
			r_b = r_a + FullTurn;
		end else if (r_a >= FullTurn) begin
			r_b = r_a - FullTurn;
		end else begin
			r_b = r_a;
		end
		r = r_b[14:0];
		if (r < QuarterTurn) begin
			q = 2'd0;
			f = r[12:0];
		end else if (r < 15'(2 * QuarterTurn)) begin
			q = 2'd1;
			f = 13'(r - QuarterTurn);
		end else if (r < 15'(3 * QuarterTurn)) begin
			q = 2'd2;
			f = 13'(r - 15'(2 * QuarterTurn));
		end else begin
			q = 2'd3;
			f = 13'(r - 15'(3 * QuarterTurn));
		end
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// convert the remainder to radians, rounded
	assign zp = 38'(f_s1) * DegToRadQ30 + 38'd32;

	always_ff @(posedge clk) begin
		q_s1 <= q;
		f_s1 <= f;
		q_s2 <= q_s1;
		z_s2 <= $signed({2'b00, zp[37:6]});
	end

	assign x_sk[0] = CordicGain;
	assign y_sk[0] = '0;
	assign z_sk[0] = z_s2;
	assign q_sk[0] = q_s2;
	assign vld_sk[0] = vld_s2;

	// one rotation step per stage
	for (genvar i = 0; i < CordicSteps; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[i+1] <= 1'b0;
			end else begin
				vld_sk[i+1] <= vld_sk[i];
			end
		end
		always_ff @(posedge clk) begin
			q_sk[i+1] <= q_sk[i];
			if (z_sk[i] >= 0) begin
				x_sk[i+1] <= x_sk[i] - (y_sk[i] >>> i);
				y_sk[i+1] <= y_sk[i] + (x_sk[i] >>> i);
				z_sk[i+1] <= z_sk[i] - $signed(34'(atan_q30(5'(i))));
			end else begin
				x_sk[i+1] <= x_sk[i] + (y_sk[i] >>> i);
				y_sk[i+1] <= y_sk[i] - (x_sk[i] >>> i);
				z_sk[i+1] <= z_sk[i] + $signed(34'(atan_q30(5'(i))));
			end
		end
	end

	// unfold the quadrant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s27 <= 1'b0;
		end else begin
			vld_s27 <= vld_sk[CordicSteps];
		end
	end

	always_ff @(posedge clk) begin
		case (q_sk[CordicSteps])
			2'd1: begin
				c_s27 <= 33'(-y_sk[CordicSteps]);
				s_s27 <= 33'(x_sk[CordicSteps]);
			end
			2'd2: begin
				c_s27 <= 33'(-x_sk[CordicSteps]);
				s_s27 <= 33'(-y_sk[CordicSteps]);
			end
			2'd3: begin
				c_s27 <= 33'(y_sk[CordicSteps]);
				s_s27 <= 33'(-x_sk[CordicSteps]);
			end
			default: begin
				c_s27 <= 33'(x_sk[CordicSteps]);
				s_s27 <= 33'(y_sk[CordicSteps]);
			end
		endcase
	end

	assign out_vld = vld_s27;
	assign cos_v = c_s27;
	assign sin_v = s_s27;

endmodule

@@ sv/euler_model_matrix_builder_core.sv @@
// Top level: Euler ZYX rotation, scale and translation into a 4x4 model matrix.
//
// Raise start for one cycle while busy is low to hand in one transform item.
// The item is taken at that edge and busy then stays high while the gap
// counter runs down, which spaces items to match the result channel; that
// channel carries four columns, one per cycle. Results pass through the three
// parallel sine/cosine lanes, the product stages and the column shifter load,
// then stream out on consecutive cycles with strobe high, column 0 first and
// last_column marking column 3. Items overlap freely in the
// pipeline. The receiver cannot stall: take each column in the cycle it shows.
// base_width and base_height are read live, so write them only while idle.
module euler_model_matrix_builder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  rot_x,
	input  logic signed [15:0]  rot_y,
	input  logic signed [15:0]  rot_z,
	input  logic signed [31:0]  scale_x,
	input  logic signed [31:0]  scale_y,
	input  logic signed [31:0]  scale_z,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output logic                strobe,
	output logic [1:0]          column_index,
	output logic signed [31:0]  elem_row0,
	output logic signed [31:0]  elem_row1,
	output logic signed [31:0]  elem_row2,
	output logic signed [31:0]  elem_row3,
	output logic                last_column
);
	import emmb_pkg::*;

	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		logic signed [31:0] r;
		if (v > 67'sh7FFFFFFF) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -67'sh80000000) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic signed [67:0] p;
		p = a * b + 68'sd536870912;
		return p[63:30];
	endfunction

	logic [31:0] base_width_q, base_height_q;
	logic [1:0] gap_q;
	logic accept, cfg_wr;
	reg_idx_t cfg_idx;

	logic cvld_x, cvld_y, cvld_z, cvld;
	trig_t cx, sx, cy, sy, cz, sz;

	logic signed [64:0] wprod_s1, hprod_s1;
	logic signed [31:0] fd_s1, px_s1, py_s1, pz_s1;
	side_t side_s2;
	side_t side_dly [0:CordicLat-3];
	side_t side_s28, side_s29, side_s30, side_s31, side_s32;

	logic vld_s28, vld_s29, vld_s30, vld_s31, vld_s32;
	logic signed [33:0] cycz_s28, cysz_s28, syx_s28, syc_s28, szcx_s28;
	logic signed [33:0] cxcz_s28, cysx_s28, cycx_s28, szsx_s28, czsx_s28;
	logic signed [33:0] sy_s28, cz_s28, sz_s28;
	logic signed [33:0] cycz_s29, cysz_s29, szcx_s29, cxcz_s29, cysx_s29;
	logic signed [33:0] cycx_s29, szsx_s29, czsx_s29, sy_s29;
	logic signed [33:0] syxcz_s29, syxsz_s29, syccz_s29, sycsz_s29;
	logic signed [33:0] ent_s30 [0:8];
	logic signed [65:0] prod_s31 [0:8];
	logic signed [31:0] elem_s32 [0:8];

	logic act_q;
	logic [1:0] col_q;
	logic signed [31:0] row0_q [0:3];
	logic signed [31:0] row1_q [0:3];
	logic signed [31:0] row2_q [0:3];

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_width_q <= 32'(OneQ16);
			base_height_q <= 32'(OneQ16);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_BASE_WIDTH: base_width_q <= pwdata;
				REG_BASE_HEIGHT: base_height_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_BASE_HEIGHT: prdata = base_height_q;
			default: prdata = base_width_q;
		endcase
	end

	// hold busy while the gap counter runs down, to space items
	assign accept = start & ~busy;
	assign busy = (gap_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
		end else if (accept) begin
			gap_q <= 2'd3;
		end else if (gap_q != 2'd0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	// three sine/cosine lanes
	emmb_cordic u_lane_x (
		.clk(clk), .arst_n(arst_n), .in_vld(accept), .angle(rot_x),
		.out_vld(cvld_x), .cos_v(cx), .sin_v(sx)
	);
	emmb_cordic u_lane_y (
		.clk(clk), .arst_n(arst_n), .in_vld(accept), .angle(rot_y),
		.out_vld(cvld_y), .cos_v(cy), .sin_v(sy)
	);
	emmb_cordic u_lane_z (
		.clk(clk), .arst_n(arst_n), .in_vld(accept), .angle(rot_z),
		.out_vld(cvld_z), .cos_v(cz), .sin_v(sz)
	);
	assign cvld = cvld_x & cvld_y & cvld_z;

	// final scales, then hold them beside the lanes
	always_ff @(posedge clk) begin
		wprod_s1 <= $signed({1'b0, base_width_q}) * scale_x;
		hprod_s1 <= $signed({1'b0, base_height_q}) * scale_y;
		fd_s1 <= scale_z;
		px_s1 <= pos_x;
		py_s1 <= pos_y;
		pz_s1 <= pos_z;
		side_s2.fw <= sat32(67'((wprod_s1 + 65'sd32768) >>> 16));
		side_s2.fh <= sat32(67'((hprod_s1 + 65'sd32768) >>> 16));
		side_s2.fd <= fd_s1;
		side_s2.px <= px_s1;
		side_s2.py <= py_s1;
		side_s2.pz <= pz_s1;
		side_dly[0] <= side_s2;
		for (int k = 1; k <= CordicLat - 3; k++) begin
			side_dly[k] <= side_dly[k-1];
		end
	end

	// product pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s28 <= 1'b0;
			vld_s29 <= 1'b0;
			vld_s30 <= 1'b0;
			vld_s31 <= 1'b0;
			vld_s32 <= 1'b0;
		end else begin
			vld_s28 <= cvld;
			vld_s29 <= vld_s28;
			vld_s30 <= vld_s29;
			vld_s31 <= vld_s30;
			vld_s32 <= vld_s31;
		end
	end

	// rotation entries, scaling and saturation
	always_ff @(posedge clk) begin
		side_s28 <= side_dly[CordicLat-3];
		cycz_s28 <= mul30(34'(cy), 34'(cz));
		cysz_s28 <= mul30(34'(cy), 34'(sz));
		syx_s28 <= mul30(34'(sy), 34'(sx));
		syc_s28 <= mul30(34'(sy), 34'(cx));
		szcx_s28 <= mul30(34'(sz), 34'(cx));
		cxcz_s28 <= mul30(34'(cx), 34'(cz));
		cysx_s28 <= mul30(34'(cy), 34'(sx));
		cycx_s28 <= mul30(34'(cy), 34'(cx));
		szsx_s28 <= mul30(34'(sz), 34'(sx));
		czsx_s28 <= mul30(34'(cz), 34'(sx));
		sy_s28 <= 34'(sy);
		cz_s28 <= 34'(cz);
		sz_s28 <= 34'(sz);

		side_s29 <= side_s28;
		syxcz_s29 <= mul30(syx_s28, cz_s28);
		syxsz_s29 <= mul30(syx_s28, sz_s28);
		syccz_s29 <= mul30(syc_s28, cz_s28);
		sycsz_s29 <= mul30(syc_s28, sz_s28);
		cycz_s29 <= cycz_s28;
		cysz_s29 <= cysz_s28;
		szcx_s29 <= szcx_s28;
		cxcz_s29 <= cxcz_s28;
		cysx_s29 <= cysx_s28;
		cycx_s29 <= cycx_s28;
		szsx_s29 <= szsx_s28;
		czsx_s29 <= czsx_s28;
		sy_s29 <= sy_s28;

		side_s30 <= side_s29;
		ent_s30[0] <= cycz_s29;
		ent_s30[1] <= cysz_s29;
		ent_s30[2] <= -sy_s29;
		ent_s30[3] <= syxcz_s29 - szcx_s29;
		ent_s30[4] <= syxsz_s29 + cxcz_s29;
		ent_s30[5] <= cysx_s29;
		ent_s30[6] <= syccz_s29 + szsx_s29;
		ent_s30[7] <= sycsz_s29 - czsx_s29;
		ent_s30[8] <= cycx_s29;

		side_s31 <= side_s30;
		for (int j = 0; j < 3; j++) begin
			prod_s31[j] <= ent_s30[j] * side_s30.fw;
			prod_s31[j+3] <= ent_s30[j+3] * side_s30.fh;
			prod_s31[j+6] <= ent_s30[j+6] * side_s30.fd;
		end

		side_s32 <= side_s31;
		for (int j = 0; j < 9; j++) begin
			elem_s32[j] <= sat32(67'((prod_s31[j] + 66'sd536870912) >>> 30));
		end
	end

	// column shifter: load a whole matrix, shift one column out per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			col_q <= 2'd0;
		end else if (vld_s32) begin
			act_q <= 1'b1;
			col_q <= 2'd0;
		end else if (act_q) begin
			col_q <= col_q + 2'd1;
			if (col_q == 2'd3) begin
				act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s32) begin
			for (int k = 0; k < 3; k++) begin
				row0_q[k] <= elem_s32[3*k];
				row1_q[k] <= elem_s32[3*k+1];
				row2_q[k] <= elem_s32[3*k+2];
			end
			row0_q[3] <= side_s32.px;
			row1_q[3] <= side_s32.py;
			row2_q[3] <= side_s32.pz;
		end else begin
			for (int k = 0; k < 3; k++) begin
				row0_q[k] <= row0_q[k+1];
				row1_q[k] <= row1_q[k+1];
				row2_q[k] <= row2_q[k+1];
			end
		end
	end

	assign strobe = act_q;
	assign column_index = col_q;
	assign elem_row0 = row0_q[0];
	assign elem_row1 = row1_q[0];
	assign elem_row2 = row2_q[0];
	assign elem_row3 = (col_q == 2'd3) ? OneQ16 : 32'sd0;
	assign last_column = (col_q == 2'd3);

	// a taken item keeps busy high for the whole item spacing
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy ##1 busy ##1 busy)
		else $error("busy dropped inside the item spacing");

	// columns stream in order without gaps
	a_col_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && column_index != 2'd3 |=>
			strobe && column_index == $past(column_index) + 2'd1)
		else $error("column sequence broken");

	// a new matrix only starts after the last column
	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s32 |-> !act_q || col_q == 2'd3)
		else $error("matrix loaded over an unfinished one");

	// all three lanes stay in step
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		cvld_x == cvld_y && cvld_y == cvld_z)
		else $error("sine/cosine lanes out of step");

endmodule
